[rtl/hrhs_pkg.sv]
// Package for the HTTP response header scanner.
// Holds the sizing constants, character codes, phase type, the structs passed
// between modules and the fixed header-name pattern lookups. No dependencies.
package hrhs_pkg;

   // Sizing
   localparam int KEY_CHARS    = 18;
   localparam int VALUE_CHARS  = 7;
   localparam int BUFFER_BYTES = 4096;

   localparam int KEY_CNT_W = $clog2(KEY_CHARS + 1);
   localparam int VAL_CNT_W = $clog2(VALUE_CHARS + 1);
   localparam int POS_W     = $clog2(BUFFER_BYTES);
   localparam int NUM_W     = 25;
   localparam int MAG_W     = 24;
   localparam int OFFSET_W  = 12;
   localparam int RSP_DATA_W = 64;

   // Lengths of the header-name and value patterns
   localparam int STATUS_LEN   = 4;
   localparam int LENGTH_LEN   = 15;
   localparam int ENCODING_LEN = 18;
   localparam int CHUNKED_LEN  = 7;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;

   // Position of a header line being scanned
   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_START_CR = 3'd1,
      PH_KEY_WS   = 3'd2,
      PH_KEY      = 3'd3,
      PH_VAL_WS   = 3'd4,
      PH_VAL      = 3'd5,
      PH_TAIL     = 3'd6,
      PH_HALT     = 3'd7
   } phase_type;

   // Number conversion stage of a value
   typedef enum logic [1:0] {
      CV_LEAD   = 2'd0,
      CV_DIGITS = 2'd1,
      CV_DONE   = 2'd2
   } conv_type;

   // Control from the scanner to the value unit
   typedef struct packed {
      logic       clear;
      logic       add;
      logic [7:0] ch;
   } val_ctrl_type;

   // Status from the value unit to the scanner
   typedef struct packed {
      logic signed [NUM_W-1:0] number;
      logic                    chunked_ok;
   } val_stat_type;

   // One result beat
   typedef struct packed {
      logic                    valid;
      logic                    outcome;
      logic signed [NUM_W-1:0] status_code;
      logic signed [NUM_W-1:0] declared_length;
      logic                    chunked;
      logic [OFFSET_W-1:0]     body_offset;
   } result_type;

   function automatic logic [7:0] lower_of(input logic [7:0] c);
      lower_of = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] status_char(input logic [KEY_CNT_W-1:0] idx);
      case (idx)
         0: status_char = "h";
         1: status_char = "t";
         2: status_char = "t";
         3: status_char = "p";
         default: status_char = CH_NUL;
      endcase
   endfunction

   function automatic logic [7:0] length_char(input logic [KEY_CNT_W-1:0] idx);
      case (idx)
         0: length_char = "c";
         1: length_char = "o";
         2: length_char = "n";
         3: length_char = "t";
         4: length_char = "e";
         5: length_char = "n";
         6: length_char = "t";
         7: length_char = "-";
         8: length_char = "l";
         9: length_char = "e";
         10: length_char = "n";
         11: length_char = "g";
         12: length_char = "t";
         13: length_char = "h";
         14: length_char = ":";
         default: length_char = CH_NUL;
      endcase
   endfunction

   function automatic logic [7:0] encoding_char(input logic [KEY_CNT_W-1:0] idx);
      case (idx)
         0: encoding_char = "t";
         1: encoding_char = "r";
         2: encoding_char = "a";
         3: encoding_char = "n";
         4: encoding_char = "s";
         5: encoding_char = "f";
         6: encoding_char = "e";
         7: encoding_char = "r";
         8: encoding_char = "-";
         9: encoding_char = "e";
         10: encoding_char = "n";
         11: encoding_char = "c";
         12: encoding_char = "o";
         13: encoding_char = "d";
         14: encoding_char = "i";
         15: encoding_char = "n";
         16: encoding_char = "g";
         17: encoding_char = ":";
         default: encoding_char = CH_NUL;
      endcase
   endfunction

   function automatic logic [7:0] chunked_char(input logic [VAL_CNT_W-1:0] idx);
      case (idx)
         0: chunked_char = "c";
         1: chunked_char = "h";
         2: chunked_char = "u";
         3: chunked_char = "n";
         4: chunked_char = "k";
         5: chunked_char = "e";
         6: chunked_char = "d";
         default: chunked_char = CH_NUL;
      endcase
   endfunction

endpackage

[rtl/http_response_header_scanner.sv]
// Top level of the HTTP response header scanner: input register stage,
// line scanner and result register with stream handshakes.
// Depends on hrhs_pkg and hrhs_scan.
//
//  channel | direction | tdata                                 | tuser    | tlast
//  req     | in        | [7:0] data_byte                       | -        | end_of_buffer
//  rsp     | out       | status, length, chunked, body_offset  | outcome  | -
//
// One byte is accepted per cycle while no result waits on rsp; the per-byte state
// update is a single register-to-register step after the input register.
// A result is formed from the byte in the input register and registered for rsp.
// Reset is synchronous and returns the scanner to the start of a buffer.
// A waiting result holds the scanner, yet one more byte is taken into the
// input register while it waits.
module http_response_header_scanner
   import hrhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_buffer
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [24:0] status_code, [49:25] declared length, [50] chunked,
   // [62:51] body_offset, [63] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser    // outcome
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   logic                  in_last_ff, in_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_outcome_ff, rsp_outcome_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic       advance;
   result_type result;

   // The held byte moves on once the result register can take its outcome.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register stage.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   hrhs_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (advance),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_last_ff),
      .result        (result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_data_in    = rsp_data_ff;
      if (result.valid) begin
         rsp_valid_in   = 1'b1;
         rsp_outcome_in = result.outcome;
         rsp_data_in    = {1'b0, result.body_offset, result.chunked,
                           result.declared_length, result.status_code};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_outcome_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/hrhs_value.sv]
// Value unit of the HTTP response header scanner: decimal conversion with
// saturation, sign handling and "chunked" prefix detection.
// Depends on hrhs_pkg.
module hrhs_value
   import hrhs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  val_ctrl_type ctrl,
   output val_stat_type stat
);

   logic [VAL_CNT_W-1:0] count_ff, count_in;
   logic [MAG_W-1:0]     acc_ff, acc_in;
   logic                 minus_ff, minus_in;
   conv_type             conv_ff, conv_in;
   logic                 prefix_ff, prefix_in;

   logic                 room;
   logic                 digit;
   logic                 lead_blank;
   logic [3:0]           digit_val;
   logic [MAG_W+3:0]     acc_next;

   // Accumulate one decimal digit; the product fits in four extra bits.
   assign digit      = ctrl.ch >= CH_ZERO && ctrl.ch <= CH_NINE;
   assign digit_val  = 4'(ctrl.ch - CH_ZERO);
   assign lead_blank = ctrl.ch == CH_SPACE || (ctrl.ch >= CH_TAB && ctrl.ch <= CH_CR);
   assign acc_next   = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                       + {{MAG_W{1'b0}}, digit_val};
   assign room       = count_ff < VAL_CNT_W'(VALUE_CHARS);

   // Next state of the value registers.
   always_comb begin
      count_in  = count_ff;
      acc_in    = acc_ff;
      minus_in  = minus_ff;
      conv_in   = conv_ff;
      prefix_in = prefix_ff;
      if (ctrl.clear) begin
         count_in  = '0;
         acc_in    = '0;
         minus_in  = 1'b0;
         conv_in   = CV_LEAD;
         prefix_in = 1'b1;
      end else if (ctrl.add && room) begin
         count_in = count_ff + 1'b1;
         if (count_ff < VAL_CNT_W'(CHUNKED_LEN) && lower_of(ctrl.ch) != chunked_char(count_ff)) begin
            prefix_in = 1'b0;
         end
         case (conv_ff)
            CV_LEAD: begin
               if (lead_blank) begin
                  conv_in = CV_LEAD;
               end else if (ctrl.ch == CH_PLUS) begin
                  conv_in = CV_DIGITS;
               end else if (ctrl.ch == CH_MINUS) begin
                  conv_in  = CV_DIGITS;
                  minus_in = 1'b1;
               end else if (digit) begin
                  conv_in = CV_DIGITS;
                  acc_in  = {{(MAG_W-4){1'b0}}, digit_val};
               end else begin
                  conv_in = CV_DONE;
               end
            end
            CV_DIGITS: begin
               if (digit) begin
                  acc_in = (acc_next > {4'd0, {MAG_W{1'b1}}}) ? {MAG_W{1'b1}}
                                                             : acc_next[MAG_W-1:0];
               end else begin
                  conv_in = CV_DONE;
               end
            end
            default: begin
               conv_in = conv_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         acc_ff    <= '0;
         minus_ff  <= 1'b0;
         conv_ff   <= CV_LEAD;
         prefix_ff <= 1'b1;
      end else begin
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         minus_ff  <= minus_in;
         conv_ff   <= conv_in;
         prefix_ff <= prefix_in;
      end
   end

   // Signed number and chunked detection seen by the line commit.
   assign stat.number     = minus_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
   assign stat.chunked_ok = prefix_ff && count_ff >= VAL_CNT_W'(CHUNKED_LEN);

endmodule

[rtl/hrhs_scan.sv]
// Line scanner of the HTTP response header scanner: line phase, key matching,
// held header values, byte position and result formation for one byte.
// Depends on hrhs_pkg and hrhs_value.
module hrhs_scan
   import hrhs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  logic [7:0] data_byte,
   input  logic       end_of_buffer,
   output result_type result
);

   phase_type               phase_ff, phase_in;
   logic [KEY_CNT_W-1:0]    key_count_ff, key_count_in;
   logic [2:0]              key_flags_ff, key_flags_in;
   logic                    prev_cr_ff, prev_cr_in;
   logic signed [NUM_W-1:0] status_ff, status_in;
   logic signed [NUM_W-1:0] length_ff, length_in;
   logic                    chunked_ff, chunked_in;
   logic [POS_W-1:0]        pos_ff, pos_in;

   logic         eob;
   logic         halted;
   logic         is_blank;
   logic         key_add;
   logic         cr_key;
   logic         val_add;
   logic         commit;
   logic         sc_ok;
   logic         sc_err;
   logic         res_err;
   logic [7:0]   key_lc;
   logic [2:0]   key_flags_add;
   val_ctrl_type vctrl;
   val_stat_type vstat;

   assign eob      = end_of_buffer || pos_ff >= POS_W'(BUFFER_BYTES - 1);
   assign halted   = phase_ff == PH_HALT;
   assign is_blank = data_byte == CH_SPACE || data_byte == CH_TAB;

   // Decode of the byte against the line phase.
   always_comb begin
      key_add = 1'b0;
      cr_key  = 1'b0;
      val_add = 1'b0;
      commit  = 1'b0;
      sc_ok   = 1'b0;
      sc_err  = 1'b0;
      if (!halted) begin
         if (data_byte == CH_NUL) begin
            sc_err = 1'b1;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (data_byte == CH_LF) begin
                     sc_err = 1'b1;
                  end else if (data_byte != CH_CR && !is_blank) begin
                     key_add = 1'b1;
                  end
               end
               PH_START_CR: begin
                  // A CR at line start that is not followed by LF joins the key.
                  if (data_byte == CH_LF) begin
                     sc_ok = 1'b1;
                  end else begin
                     cr_key = 1'b1;
                  end
               end
               PH_KEY_WS: begin
                  if (data_byte == CH_LF) begin
                     sc_err = 1'b1;
                  end else if (!is_blank) begin
                     key_add = 1'b1;
                  end
               end
               PH_KEY: begin
                  if (data_byte == CH_LF) begin
                     sc_err = 1'b1;
                  end else if (data_byte != CH_SPACE) begin
                     key_add = 1'b1;
                  end
               end
               PH_VAL_WS: begin
                  if (data_byte == CH_LF) begin
                     sc_err = 1'b1;
                  end else if (!is_blank) begin
                     val_add = 1'b1;
                  end
               end
               PH_VAL: begin
                  if (data_byte == CH_LF) begin
                     commit = prev_cr_ff;
                  end else if (data_byte != CH_SPACE) begin
                     val_add = 1'b1;
                  end
               end
               PH_TAIL: begin
                  commit = data_byte == CH_LF && prev_cr_ff;
               end
               default: begin
                  sc_err = 1'b0;
               end
            endcase
         end
      end
   end

   assign res_err = sc_err || (!halted && !sc_ok && eob);

   // Next line phase.
   always_comb begin
      phase_in = phase_ff;
      if (eob) begin
         phase_in = PH_START;
      end else if (sc_ok || res_err) begin
         phase_in = PH_HALT;
      end else if (commit) begin
         phase_in = PH_START;
      end else begin
         case (phase_ff)
            PH_START: begin
               if (data_byte == CH_CR) begin
                  phase_in = PH_START_CR;
               end else if (is_blank) begin
                  phase_in = PH_KEY_WS;
               end else begin
                  phase_in = PH_KEY;
               end
            end
            PH_START_CR: begin
               phase_in = (data_byte == CH_SPACE) ? PH_VAL_WS : PH_KEY;
            end
            PH_KEY_WS: begin
               phase_in = is_blank ? PH_KEY_WS : PH_KEY;
            end
            PH_KEY: begin
               phase_in = (data_byte == CH_SPACE) ? PH_VAL_WS : PH_KEY;
            end
            PH_VAL_WS: begin
               phase_in = is_blank ? PH_VAL_WS : PH_VAL;
            end
            PH_VAL: begin
               phase_in = (data_byte == CH_SPACE || data_byte == CH_LF) ? PH_TAIL : PH_VAL;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Key prefix match against the three header names.
   assign key_lc = lower_of(data_byte);
   always_comb begin
      key_flags_add = key_flags_ff;
      if (key_count_ff < KEY_CNT_W'(STATUS_LEN) && key_lc != status_char(key_count_ff)) begin
         key_flags_add[0] = 1'b0;
      end
      if (key_count_ff < KEY_CNT_W'(LENGTH_LEN) && key_lc != length_char(key_count_ff)) begin
         key_flags_add[1] = 1'b0;
      end
      if (key_count_ff < KEY_CNT_W'(ENCODING_LEN) && key_lc != encoding_char(key_count_ff)) begin
         key_flags_add[2] = 1'b0;
      end
   end

   // Next key, held-value and position state.
   always_comb begin
      key_count_in = key_count_ff;
      key_flags_in = key_flags_ff;
      status_in    = status_ff;
      length_in    = length_ff;
      chunked_in   = chunked_ff;
      prev_cr_in   = data_byte == CH_CR;
      pos_in       = pos_ff + 1'b1;
      if (eob) begin
         key_count_in = '0;
         key_flags_in = 3'b111;
         status_in    = '0;
         length_in    = '0;
         chunked_in   = 1'b0;
         prev_cr_in   = 1'b0;
         pos_in       = '0;
      end else if (commit) begin
         if (key_flags_ff[0] && key_count_ff >= KEY_CNT_W'(STATUS_LEN)) begin
            status_in = vstat.number;
         end else if (key_flags_ff[1] && key_count_ff >= KEY_CNT_W'(LENGTH_LEN)) begin
            length_in  = vstat.number;
            chunked_in = 1'b0;
         end else if (key_flags_ff[2] && key_count_ff >= KEY_CNT_W'(ENCODING_LEN)) begin
            if (vstat.chunked_ok) begin
               chunked_in = 1'b1;
            end
         end
         key_count_in = '0;
         key_flags_in = 3'b111;
      end else if (cr_key) begin
         // The CR matches no pattern; a following non-space adds a second character.
         key_flags_in = 3'b000;
         key_count_in = (data_byte == CH_SPACE) ? KEY_CNT_W'(1) : KEY_CNT_W'(2);
      end else if (key_add && key_count_ff < KEY_CNT_W'(KEY_CHARS)) begin
         key_flags_in = key_flags_add;
         key_count_in = key_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         key_count_ff <= '0;
         key_flags_ff <= 3'b111;
         prev_cr_ff   <= 1'b0;
         status_ff    <= '0;
         length_ff    <= '0;
         chunked_ff   <= 1'b0;
         pos_ff       <= '0;
      end else if (item_valid) begin
         phase_ff     <= phase_in;
         key_count_ff <= key_count_in;
         key_flags_ff <= key_flags_in;
         prev_cr_ff   <= prev_cr_in;
         status_ff    <= status_in;
         length_ff    <= length_in;
         chunked_ff   <= chunked_in;
         pos_ff       <= pos_in;
      end
   end

   // Value conversion unit.
   assign vctrl.clear = item_valid && (commit || eob);
   assign vctrl.add   = item_valid && val_add;
   assign vctrl.ch    = data_byte;

   hrhs_value u_value (
      .clock (clock),
      .reset (reset),
      .ctrl  (vctrl),
      .stat  (vstat)
   );

   // Result beat; an error carries all fields at zero.
   always_comb begin
      result.valid           = item_valid && (sc_ok || res_err);
      result.outcome         = !sc_ok;
      result.status_code     = sc_ok ? status_ff : '0;
      result.declared_length = sc_ok ? length_ff : '0;
      result.chunked         = sc_ok && chunked_ff;
      result.body_offset     = sc_ok ? OFFSET_W'({1'b0, pos_ff} + 1'b1) : '0;
   end

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.outcome |->
         result.status_code == '0 && result.declared_length == '0 &&
         !result.chunked && result.body_offset == '0)
      else $error("error beat carries non-zero fields");

   a_halt_after_result: assert property (@(posedge clock) disable iff (reset)
      result.valid && !eob |=> phase_ff == PH_HALT)
      else $error("scanner did not halt after a result");

   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      item_valid && eob |=> pos_ff == '0 && phase_ff == PH_START && !prev_cr_ff)
      else $error("end of buffer did not restart the scanner");

   a_key_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KEY_CNT_W'(KEY_CHARS))
      else $error("key count past its cap");
`endif

endmodule

[test/tb_http_response_header_scanner.sv]
// Self-checking testbench for http_response_header_scanner: a directed table of
// header bytes, then random response buffers, checked against a local model.
// Depends on hrhs_pkg and the scanner RTL.
module tb_http_response_header_scanner
   import hrhs_pkg::*;
();

   // What a stimulus beat expects: worked out by the model, or typed in below
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_ERROR,
      ROW_HEADER
   } row_kind_type;

   typedef struct packed {
      logic [7:0]          data;
      logic                last;
      logic                hold;     // wait for every result before offering
      row_kind_type        kind;
      logic [OFFSET_W-1:0] offset;   // body offset of a typed header result
   } stim_beat_type;

   typedef struct packed {
      logic                    outcome;
      logic signed [NUM_W-1:0] status_code;
      logic signed [NUM_W-1:0] content_len;
      logic                    chunked;
      logic [OFFSET_W-1:0]     offset;
   } header_outcome_type;

   typedef enum logic [1:0] {
      SCAN_BUSY,
      SCAN_GOOD,
      SCAN_BAD
   } verdict_type;

   localparam int RANDOM_ITEMS   = 1100;
   localparam int RANDOM_BUFFERS = 40;
   localparam int LONG_HOLD      = 300;
   localparam int DIRECTED_ROWS  = 23;

   localparam logic [8*STATUS_LEN-1:0]   WORD_STATUS   = "http";
   localparam logic [8*LENGTH_LEN-1:0]   WORD_LENGTH   = "content-length:";
   localparam logic [8*ENCODING_LEN-1:0] WORD_ENCODING = "transfer-encoding:";
   localparam logic [8*CHUNKED_LEN-1:0]  WORD_CHUNKED  = "chunked";
   localparam logic [7:0] CH_VT = 8'h0b;
   localparam logic [7:0] CH_FF = 8'h0c;
   localparam int unsigned MAG_LIMIT = 32'h00ff_ffff;

   // Directed beats: bare LF, zero byte, unterminated buffer, key into a lone LF,
   // an empty header, and a status line with a blank before a signed value.
   localparam stim_beat_type DIRECTED_BEATS [DIRECTED_ROWS] = '{
      '{CH_LF,    1'b0, 1'b0, ROW_ERROR,   12'd0},
      '{8'hff,    1'b1, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_NUL,   1'b1, 1'b0, ROW_ERROR,   12'd0},
      '{"A",      1'b1, 1'b0, ROW_ERROR,   12'd0},
      '{"k",      1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_LF,    1'b1, 1'b0, ROW_ERROR,   12'd0},
      '{CH_CR,    1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_LF,    1'b0, 1'b0, ROW_HEADER,  12'd2},
      '{"x",      1'b1, 1'b0, ROW_PREDICT, 12'd0},
      '{"h",      1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{"T",      1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{"t",      1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{"P",      1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_SPACE, 1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_VT,    1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_MINUS, 1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{"1",      1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{"2",      1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_CR,    1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_LF,    1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_CR,    1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{CH_LF,    1'b0, 1'b0, ROW_PREDICT, 12'd0},
      '{8'h80,    1'b1, 1'b0, ROW_PREDICT, 12'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   stim_beat_type      stim[$];
   header_outcome_type pending_results[$];
   int                 beats_taken = 0;
   int                 results_seen = 0;
   int                 failures = 0;
   bit                 long_hold_done = 1'b0;

   // Scanner model state
   phase_type               line_state;
   conv_type                conv_state;
   int unsigned             key_len;
   int unsigned             value_len;
   int unsigned             magnitude;
   int unsigned             byte_index;
   logic [2:0]              key_hits;
   bit                      negative;
   bit                      chunk_prefix;
   bit                      cr_before;
   logic signed [NUM_W-1:0] status_keep;
   logic signed [NUM_W-1:0] length_keep;
   bit                      chunked_keep;

   http_response_header_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic [7:0] word_char(input logic [8*ENCODING_LEN-1:0] word,
                                            input int len, input int unsigned pos);
      return word[8*(len-1-pos) +: 8];
   endfunction

   function automatic void clear_line_state();
      key_len      = 0;
      key_hits     = 3'b111;
      value_len    = 0;
      magnitude    = 0;
      negative     = 1'b0;
      conv_state   = CV_LEAD;
      chunk_prefix = 1'b1;
   endfunction

   function automatic void restart_scan();
      clear_line_state();
      line_state   = PH_START;
      status_keep  = '0;
      length_keep  = '0;
      chunked_keep = 1'b0;
      byte_index   = 0;
      cr_before    = 1'b0;
   endfunction

   // Key characters narrow down which of the three known names can still match.
   function automatic void key_take(input logic [7:0] c);
      logic [7:0] lc;
      lc = fold_case(c);
      if (key_len < KEY_CHARS) begin
         if (key_len < STATUS_LEN &&
             lc != word_char((8*ENCODING_LEN)'(WORD_STATUS), STATUS_LEN, key_len)) begin
            key_hits[0] = 1'b0;
         end
         if (key_len < LENGTH_LEN &&
             lc != word_char((8*ENCODING_LEN)'(WORD_LENGTH), LENGTH_LEN, key_len)) begin
            key_hits[1] = 1'b0;
         end
         if (key_len < ENCODING_LEN &&
             lc != word_char(WORD_ENCODING, ENCODING_LEN, key_len)) begin
            key_hits[2] = 1'b0;
         end
         key_len++;
      end
   endfunction

   // Value characters feed both the number conversion and the chunked check.
   function automatic void value_take(input logic [7:0] c);
      bit          digit;
      int unsigned next_mag;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      if (value_len >= VALUE_CHARS) begin
         return;
      end
      if (value_len < CHUNKED_LEN &&
          fold_case(c) != word_char((8*ENCODING_LEN)'(WORD_CHUNKED), CHUNKED_LEN,
                                    value_len)) begin
         chunk_prefix = 1'b0;
      end
      value_len++;
      case (conv_state)
         CV_LEAD: begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
               conv_state = CV_LEAD;
            end else if (c == CH_PLUS) begin
               conv_state = CV_DIGITS;
            end else if (c == CH_MINUS) begin
               conv_state = CV_DIGITS;
               negative   = 1'b1;
            end else if (digit) begin
               conv_state = CV_DIGITS;
               magnitude  = 32'(c - CH_ZERO);
            end else begin
               conv_state = CV_DONE;
            end
         end
         CV_DIGITS: begin
            if (digit) begin
               next_mag  = magnitude * 10 + 32'(c - CH_ZERO);
               magnitude = (next_mag > MAG_LIMIT) ? MAG_LIMIT : next_mag;
            end else begin
               conv_state = CV_DONE;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic signed [NUM_W-1:0] value_number();
      return negative ? NUM_W'(0 - magnitude) : NUM_W'(magnitude);
   endfunction

   // A finished line updates whichever header it names.
   function automatic void commit_line();
      if (key_hits[0] && key_len >= STATUS_LEN) begin
         status_keep = value_number();
      end else if (key_hits[1] && key_len >= LENGTH_LEN) begin
         length_keep  = value_number();
         chunked_keep = 1'b0;
      end else if (key_hits[2] && key_len >= ENCODING_LEN) begin
         if (chunk_prefix && value_len >= CHUNKED_LEN) begin
            chunked_keep = 1'b1;
         end
      end
      clear_line_state();
      line_state = PH_START;
   endfunction

   function automatic verdict_type scan_line_byte(input logic [7:0] b);
      bit blank;
      bit key_step;
      blank    = (b == CH_SPACE || b == CH_TAB);
      key_step = 1'b0;
      if (b == CH_NUL) begin
         return SCAN_BAD;
      end
      case (line_state)
         PH_START: begin
            if (b == CH_CR) begin
               line_state = PH_START_CR;
            end else if (b == CH_LF) begin
               return SCAN_BAD;
            end else if (blank) begin
               line_state = PH_KEY_WS;
            end else begin
               key_take(b);
               line_state = PH_KEY;
            end
         end
         PH_START_CR: begin
            if (b == CH_LF) begin
               return SCAN_GOOD;
            end
            // The CR was not a blank line after all: it opens a key.
            key_take(CH_CR);
            line_state = PH_KEY;
            key_step   = 1'b1;
         end
         PH_KEY_WS: begin
            if (b == CH_LF) begin
               return SCAN_BAD;
            end
            if (!blank) begin
               key_take(b);
               line_state = PH_KEY;
            end
         end
         PH_KEY: begin
            key_step = 1'b1;
         end
         PH_VAL_WS: begin
            if (b == CH_LF) begin
               return SCAN_BAD;
            end
            if (!blank) begin
               value_take(b);
               line_state = PH_VAL;
            end
         end
         PH_VAL: begin
            if (b == CH_SPACE) begin
               line_state = PH_TAIL;
            end else if (b == CH_LF) begin
               if (cr_before) begin
                  commit_line();
               end else begin
                  line_state = PH_TAIL;
               end
            end else begin
               value_take(b);
            end
         end
         PH_TAIL: begin
            if (b == CH_LF && cr_before) begin
               commit_line();
            end
         end
         default: begin
         end
      endcase
      if (key_step) begin
         if (b == CH_LF) begin
            return SCAN_BAD;
         end
         if (b == CH_SPACE) begin
            line_state = PH_VAL_WS;
         end else begin
            key_take(b);
         end
      end
      return SCAN_BUSY;
   endfunction

   // Advances the model by one accepted beat; returns 1 when a result is due.
   function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                       output header_outcome_type res);
      bit          eob;
      verdict_type verdict;
      eob     = last || (byte_index >= BUFFER_BYTES - 1);
      verdict = SCAN_BUSY;
      res     = '0;
      if (line_state != PH_HALT) begin
         verdict = scan_line_byte(b);
         if (verdict == SCAN_BUSY && eob) begin
            verdict = SCAN_BAD;
         end
      end
      if (verdict == SCAN_GOOD) begin
         res.status_code = status_keep;
         res.content_len = length_keep;
         res.chunked     = chunked_keep;
         res.offset      = OFFSET_W'(byte_index + 1);
      end else if (verdict == SCAN_BAD) begin
         res.outcome = 1'b1;
      end
      if (verdict != SCAN_BUSY) begin
         line_state = PH_HALT;
      end
      cr_before = (b == CH_CR);
      byte_index++;
      if (eob) begin
         restart_scan();
      end
      return verdict != SCAN_BUSY;
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic add_beat(input logic [7:0] b);
      stim.push_back('{b, 1'b0, 1'b0, ROW_PREDICT, 12'd0});
   endtask

   task automatic add_text(input string s, input bit mixed);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mixed && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
            c = c - 8'd32;
         end
         add_beat(c);
      end
   endtask

   task automatic add_blanks(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) begin
         add_beat($urandom_range(0, 1) == 1 ? CH_SPACE : CH_TAB);
      end
   endtask

   task automatic add_word(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) begin
         add_beat(8'($urandom_range(33, 126)));
      end
   endtask

   task automatic add_crlf();
      add_beat(CH_CR);
      add_beat(CH_LF);
   endtask

   function automatic string number_text();
      int unsigned v;
      string       s;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 9);
         1: v = $urandom_range(0, 999);
         2: v = $urandom_range(0, 9999999);
         default: v = 9999999;
      endcase
      s = $sformatf("%0d", v);
      case ($urandom_range(0, 6))
         0: s = {"-", s};
         1: s = {"+", s};
         2: s = {"0", s};
         3: s = {"+-", s};
         default: begin
         end
      endcase
      if ($urandom_range(0, 7) == 0) begin
         s = {s, "ab"};
      end
      return s;
   endfunction

   // One header line: a known or random key, a blank run, a value and an ending.
   task automatic add_line();
      int which;
      which = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) begin
         add_blanks(1, 2);
      end
      case (which)
         0, 1: begin
            case ($urandom_range(0, 5))
               0: add_text("http/1.1", 1);
               1: add_text("http/1.0", 1);
               2: add_text("http", 1);
               3: add_text("https/2", 1);
               4: add_text("htt", 1);
               default: add_text("xhttp", 1);
            endcase
         end
         2, 3: begin
            case ($urandom_range(0, 3))
               0: add_text("content-length:", 1);
               1: add_text("content-length:x", 1);
               2: add_text("content-lengthx", 1);
               default: add_text("content-len", 1);
            endcase
         end
         4, 5: begin
            case ($urandom_range(0, 2))
               0: add_text("transfer-encoding:", 1);
               1: add_text("transfer-encoding:zz", 1);
               default: add_text("transfer-encodin", 1);
            endcase
         end
         default: add_word(1, 24);
      endcase
      add_beat(CH_SPACE);
      add_blanks(0, 2);
      if ($urandom_range(0, 6) == 0) begin
         case ($urandom_range(0, 2))
            0: add_beat(CH_CR);
            1: add_beat(CH_VT);
            default: add_beat(CH_FF);
         endcase
      end
      if (which == 4 || which == 5) begin
         case ($urandom_range(0, 5))
            0, 1: add_text("chunked", 1);
            2: add_text("chunkedx", 1);
            3: add_text("chunke", 1);
            4: add_text("gzip", 1);
            default: add_text("chunked-ish", 1);
         endcase
      end else if (which < 8) begin
         add_text(number_text(), 0);
      end else begin
         add_word(1, 10);
      end
      // Ending: plain CR LF, a space and a trailer, or a lone LF and junk.
      case ($urandom_range(0, 9))
         0: add_text(" ok", 0);
         1: begin
            add_beat(CH_LF);
            add_word(0, 3);
         end
         default: begin
         end
      endcase
      add_crlf();
   endtask

   // One received buffer: mostly a header with a short body, some broken, some noise.
   task automatic add_buffer();
      int first;
      int style;
      first = stim.size();
      style = $urandom_range(0, 19);
      if (style < 3) begin
         add_word(0, 0);
         repeat ($urandom_range(1, 30)) begin
            add_beat(8'($urandom_range(0, 255)));
         end
      end else begin
         repeat ($urandom_range(0, 4)) begin
            add_line();
         end
         add_crlf();
         repeat ($urandom_range(0, 4)) begin
            add_beat(8'($urandom_range(0, 255)));
         end
         if (style < 7) begin
            if ($urandom_range(0, 1) == 1) begin
               int keep;
               keep = $urandom_range(first + 1, stim.size());
               while (stim.size() > keep) begin
                  stim.delete(stim.size() - 1);
               end
            end else begin
               stim[$urandom_range(first, stim.size() - 1)].data =
                  ($urandom_range(0, 1) == 1) ? CH_LF : CH_NUL;
            end
         end
      end
      stim[stim.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Results are compared first, then the accepted request beat is modelled.
   always @(posedge clock) begin
      header_outcome_type got;
      header_outcome_type want;
      header_outcome_type predicted;
      stim_beat_type      beat;
      bit                 produced;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.outcome     = rsp_tuser;
            got.status_code = rsp_tdata[24:0];
            got.content_len = rsp_tdata[49:25];
            got.chunked     = rsp_tdata[50];
            got.offset      = rsp_tdata[62:51];
            results_seen++;
            if (pending_results.size() == 0) begin
               note_failure({$sformatf("result %0d unexpected: outcome %0d status %0d ",
                                       results_seen, got.outcome, got.status_code),
                             $sformatf("length %0d chunked %0d offset %0d",
                                       got.content_len, got.chunked, got.offset)});
            end else begin
               want = pending_results.pop_front();
               if (got.outcome !== want.outcome || got.status_code !== want.status_code ||
                   got.content_len !== want.content_len || got.chunked !== want.chunked ||
                   got.offset !== want.offset) begin
                  note_failure({
                     $sformatf("result %0d: expected outcome %0d status %0d length %0d ",
                               results_seen, want.outcome, want.status_code,
                               want.content_len),
                     $sformatf("chunked %0d offset %0d, got outcome %0d status %0d ",
                               want.chunked, want.offset, got.outcome, got.status_code),
                     $sformatf("length %0d chunked %0d offset %0d",
                               got.content_len, got.chunked, got.offset)});
               end
            end
         end
         if (req_tvalid && req_tready) begin
            beat = stim[beats_taken];
            beats_taken++;
            produced = predict_byte(beat.data, beat.last, predicted);
            case (beat.kind)
               ROW_ERROR: begin
                  want         = '0;
                  want.outcome = 1'b1;
                  pending_results.push_back(want);
               end
               ROW_HEADER: begin
                  want        = '0;
                  want.offset = beat.offset;
                  pending_results.push_back(want);
               end
               default: begin
                  if (produced) begin
                     pending_results.push_back(predicted);
                  end
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // Stall patterns are drawn at random run by run; one long hold-off backs up the input.
   initial begin
      int          mode;
      logic [31:0] stall_bits;
      rsp_tready <= 1'b0;
      forever begin
         mode       = $urandom_range(0, 3);
         stall_bits = $urandom;
         for (int k = 0; k < 64; k++) begin
            @(posedge clock);
            if (!long_hold_done && results_seen >= 20) begin
               long_hold_done = 1'b1;
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= stall_bits[k % 32];
                  2: rsp_tready <= ($urandom_range(0, 3) != 0);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   // ---------------------------------------------------------------- sender

   initial begin
      int buffers;
      int first;
      int burst_left;
      int gap;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      restart_scan();

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         stim.push_back(DIRECTED_BEATS[i]);
      end
      buffers = 0;
      while (stim.size() - DIRECTED_ROWS < RANDOM_ITEMS || buffers < RANDOM_BUFFERS) begin
         first = stim.size();
         add_buffer();
         if (buffers == 12) begin
            stim[first].hold = 1'b1;
         end
         buffers++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bursts of beats with random gaps; a held beat waits for every result.
      burst_left = 0;
      for (int idx = 0; idx < stim.size(); idx++) begin
         if (stim[idx].hold) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
         end else if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         req_tvalid <= 1'b1;
         req_tdata  <= stim[idx].data;
         req_tlast  <= stim[idx].last;
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending_results.size() != 0);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
